/* hdl/tem_pkg.sv */
package tem_pkg;

  localparam int unsigned ELEV_W     = 18;
  localparam int unsigned ANGLE_W    = 17;
  localparam int unsigned DIVISOR_W  = 31;
  localparam int unsigned FACTOR_W   = 22;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned SIN2_W     = 61;
  localparam int unsigned CSQ_W      = 62;
  localparam int unsigned OUT_FRAC_BITS_DEF = 16;

  localparam logic [FACTOR_W-1:0]  FACTOR_MAX = '1;
  localparam logic [DIVISOR_W-1:0] DRY_RESET  = 31'd1074829207;
  localparam logic [DIVISOR_W-1:0] WET_RESET  = 31'd1074044849;

  localparam logic [17:0] QUARTER_TURN = 18'd92160;
  localparam logic [17:0] HALF_TURN    = 18'd184320;

  // degrees (Q.10) to radians (Q.30): a * K >> 32, K split into a 23-bit high and a 24-bit low part for two products
  localparam logic [46:0] RAD_PER_DEG = 47'd78602641689205;
  localparam logic [22:0] RAD_HI      = 23'(RAD_PER_DEG >> 24);
  localparam logic [23:0] RAD_LO      = 24'(RAD_PER_DEG & 47'hFFFFFF);

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  localparam int unsigned TERMS = 8;

  // Taylor divisors 2k(2k+1), k = 8 down to 1, and floor(2^32 / divisor)
  localparam logic [8:0] DV_TAB [TERMS] = '{
    9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6};
  localparam logic [29:0] RECIP_TAB [TERMS] = '{
    30'((64'd1 << 32) / 64'd272), 30'((64'd1 << 32) / 64'd210),
    30'((64'd1 << 32) / 64'd156), 30'((64'd1 << 32) / 64'd110),
    30'((64'd1 << 32) / 64'd72),  30'((64'd1 << 32) / 64'd42),
    30'((64'd1 << 32) / 64'd20),  30'((64'd1 << 32) / 64'd6)};

  typedef enum logic {
    REG_DRY = 1'b0,
    REG_WET = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic vld;
    logic bh;
  } ctl_t;

  typedef struct packed {
    logic                sat;
    logic                bh;
    logic [FACTOR_W-1:0] wet;
    logic [FACTOR_W-1:0] dry;
  } res_t;

endpackage

/* hdl/tropo_elevation_mapping.sv */
// Tropospheric elevation mapping: for each elevation beat (signed degrees, Q.10) the
// block returns dry and wet mapping factors C/sqrt(C^2 - 1 + sin^2(el)) in unsigned
// fixed point with OUT_FRAC_BITS fraction bits, clipped to the 22-bit maximum with
// the saturated flag; negative elevation gives zero factors and below_horizon.
// Fully pipelined: one beat per cycle while the buffer's second entry is free; 30 sine
// stages, 33 square-root stages (a setup stage, then one root bit each), 23 divider
// stages (a setup stage, then one quotient bit each), one output register. A two-entry
// output buffer keeps input ready registered. Divisors (Q1.30) are written over APB at
// 0x0 (dry) and 0x4 (wet), by the user only while the pipeline is empty (unenforced).
module tropo_elevation_mapping #(
  parameter int unsigned OUT_FRAC_BITS = tem_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [17:0] elevation
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [21:0] dry_factor, [43:22] wet_factor
  output logic [1:0]  m_axis_tuser    // [0] below_horizon, [1] saturated
);

  localparam int unsigned DW = tem_pkg::DIVISOR_W;

  // ---------------- configuration ----------------
  logic [DW-1:0] dry_q, wet_q;
  logic [tem_pkg::CSQ_W-1:0] dry_sq_q, wet_sq_q;
  logic wr;
  tem_pkg::reg_idx_e idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = tem_pkg::reg_idx_e'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q <= tem_pkg::DRY_RESET;
      wet_q <= tem_pkg::WET_RESET;
    end else if (wr) begin
      unique case (idx)
        tem_pkg::REG_DRY: dry_q <= pwdata[DW-1:0];
        tem_pkg::REG_WET: wet_q <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tem_pkg::REG_DRY: prdata = {1'b0, dry_q};
      tem_pkg::REG_WET: prdata = {1'b0, wet_q};
      default:          prdata = '0;
    endcase
  end

  // C^2 is registered from the divisor register, well before any beat reaches it
  always_ff @(posedge clk_i) begin
    dry_sq_q <= tem_pkg::CSQ_W'(dry_q) * tem_pkg::CSQ_W'(dry_q);
    wet_sq_q <= tem_pkg::CSQ_W'(wet_q) * tem_pkg::CSQ_W'(wet_q);
  end

  // ---------------- pipeline ----------------
  logic en;
  tem_pkg::ctl_t in_ctl, sin_ctl, dsq_ctl, wsq_ctl, ddv_ctl, wdv_ctl;
  logic [tem_pkg::SIN2_W-1:0] sin2;
  logic [tem_pkg::ROOT_W-1:0] d_root, w_root;
  logic d_rsat, w_rsat, d_sat, w_sat;
  logic [tem_pkg::FACTOR_W-1:0] d_fac, w_fac;

  logic skid_vld_q, out_vld_q;
  tem_pkg::res_t skid_q, out_q, res;

  // whole pipeline holds while the buffer's second entry is taken
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;
  assign in_ctl.vld    = s_axis_tvalid & en;
  assign in_ctl.bh     = s_axis_tdata[17];

  tem_sin u_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (in_ctl),
    .elev_i (s_axis_tdata[tem_pkg::ELEV_W-1:0]),
    .ctl_o  (sin_ctl),
    .sin2_o (sin2)
  );

  tem_isqrt u_sqrt_dry (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (sin_ctl),
    .sin2_i (sin2),
    .csq_i  (dry_sq_q),
    .ctl_o  (dsq_ctl),
    .root_o (d_root),
    .sat_o  (d_rsat)
  );

  tem_isqrt u_sqrt_wet (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (sin_ctl),
    .sin2_i (sin2),
    .csq_i  (wet_sq_q),
    .ctl_o  (wsq_ctl),
    .root_o (w_root),
    .sat_o  (w_rsat)
  );

  tem_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_dry (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctl_i     (dsq_ctl),
    .divisor_i (dry_q),
    .root_i    (d_root),
    .sat_i     (d_rsat),
    .ctl_o     (ddv_ctl),
    .factor_o  (d_fac),
    .sat_o     (d_sat)
  );

  tem_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_wet (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctl_i     (wsq_ctl),
    .divisor_i (wet_q),
    .root_i    (w_root),
    .sat_i     (w_rsat),
    .ctl_o     (wdv_ctl),
    .factor_o  (w_fac),
    .sat_o     (w_sat)
  );

  // both lanes carry the same control bits
  logic arrive, bh, take;
  assign arrive = ddv_ctl.vld & wdv_ctl.vld & en;
  assign bh     = ddv_ctl.bh | wdv_ctl.bh;

  always_comb begin
    res.dry = bh ? '0 : d_fac;
    res.wet = bh ? '0 : w_fac;
    res.bh  = bh;
    res.sat = !bh & (d_sat | w_sat);
  end

  // ---------------- output buffer ----------------
  assign take = out_vld_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || take) begin
      out_vld_q  <= skid_vld_q | arrive;
      skid_vld_q <= 1'b0;
    end else if (arrive) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || take) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (arrive) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_q.wet, out_q.dry};
  assign m_axis_tuser  = {out_q.sat, out_q.bh};

endmodule

/* hdl/tem_sin.sv */
module tem_sin (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  tem_pkg::ctl_t                     ctl_i,
  input  logic [tem_pkg::ELEV_W-1:0]        elev_i,
  output tem_pkg::ctl_t                     ctl_o,
  output logic [tem_pkg::SIN2_W-1:0]        sin2_o
);

  localparam int unsigned N = tem_pkg::TERMS;

  // fold to [0, 90] degrees, negative angles run as zero
  logic [16:0] a_mag;
  logic [17:0] a_fold;
  logic [16:0] a_d;
  assign a_mag  = elev_i[16:0];
  assign a_fold = tem_pkg::HALF_TURN - 18'(a_mag);
  always_comb begin
    if (elev_i[17]) begin
      a_d = '0;
    end else if (18'(a_mag) > tem_pkg::QUARTER_TURN) begin
      a_d = a_fold[16:0];
    end else begin
      a_d = a_mag;
    end
  end

  tem_pkg::ctl_t c0_q, c1_q, c2_q, c3_q, cf_q, cs_q;
  logic [16:0] a_q;
  logic [39:0] pph_q;
  logic [40:0] ppl_q;
  logic [30:0] x2s_q;
  logic [30:0] x3_q;
  logic [31:0] xx3_q;
  logic [30:0] s_q;
  logic [60:0] sin2_q;

  logic [30:0]   it_x  [N+1];
  logic [31:0]   it_x2 [N+1];
  logic [30:0]   it_t  [N+1];
  tem_pkg::ctl_t it_c  [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      cf_q <= '0;
      cs_q <= '0;
    end else if (en_i) begin
      c0_q <= ctl_i;
      c1_q <= c0_q;
      c2_q <= c1_q;
      c3_q <= c2_q;
      cf_q <= it_c[N];
      cs_q <= cf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      pph_q  <= 40'(a_q) * 40'(tem_pkg::RAD_HI);
      ppl_q  <= 41'(a_q) * 41'(tem_pkg::RAD_LO);
      x2s_q  <= 31'(((64'(pph_q) << 24) + 64'(ppl_q)) >> 32);
      x3_q   <= x2s_q;
      xx3_q  <= 32'((62'(x2s_q) * 62'(x2s_q)) >> 30);
      s_q    <= 31'((62'(it_x[N]) * 62'(it_t[N])) >> 30);
      sin2_q <= 61'(62'(s_q) * 62'(s_q));
    end
  end

  assign it_x[0]  = x3_q;
  assign it_x2[0] = xx3_q;
  assign it_t[0]  = tem_pkg::Q30_ONE;
  assign it_c[0]  = c3_q;

  // one Taylor term per three stages: product, reciprocal product, correction
  for (genvar j = 0; j < N; j++) begin : g_term
    tem_pkg::ctl_t ca_q, cb_q, cc_q;
    logic [30:0] xa_q, xb_q, xc_q;
    logic [31:0] x2a_q, x2b_q, x2c_q;
    logic [31:0] pa_q, pb_q;
    logic [29:0] q0_q;
    logic [30:0] tc_q;
    logic [31:0] rem;
    logic [30:0] q;
    logic [30:0] t_d;

    always_comb begin
      rem = pb_q - 32'(39'(q0_q) * 39'(tem_pkg::DV_TAB[j]));
      q   = (rem >= 32'(tem_pkg::DV_TAB[j])) ? 31'(q0_q) + 31'd1 : 31'(q0_q);
      t_d = (q >= tem_pkg::Q30_ONE) ? '0 : tem_pkg::Q30_ONE - q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ca_q <= '0;
        cb_q <= '0;
        cc_q <= '0;
      end else if (en_i) begin
        ca_q <= it_c[j];
        cb_q <= ca_q;
        cc_q <= cb_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xa_q  <= it_x[j];
        x2a_q <= it_x2[j];
        pa_q  <= 32'((63'(it_x2[j]) * 63'(it_t[j])) >> 30);
        xb_q  <= xa_q;
        x2b_q <= x2a_q;
        pb_q  <= pa_q;
        q0_q  <= 30'((62'(pa_q) * 62'(tem_pkg::RECIP_TAB[j])) >> 32);
        xc_q  <= xb_q;
        x2c_q <= x2b_q;
        tc_q  <= t_d;
      end
    end

    assign it_x[j+1]  = xc_q;
    assign it_x2[j+1] = x2c_q;
    assign it_t[j+1]  = tc_q;
    assign it_c[j+1]  = cc_q;
  end

  assign ctl_o  = cs_q;
  assign sin2_o = sin2_q;

endmodule

/* hdl/tem_isqrt.sv */
module tem_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  tem_pkg::ctl_t                 ctl_i,
  input  logic [tem_pkg::SIN2_W-1:0]    sin2_i,
  input  logic [tem_pkg::CSQ_W-1:0]     csq_i,
  output tem_pkg::ctl_t                 ctl_o,
  output logic [tem_pkg::ROOT_W-1:0]    root_o,
  output logic                          sat_o
);

  localparam int unsigned RW = tem_pkg::ROOT_W;

  logic [62:0] num;
  assign num = 63'(csq_i) + 63'(sin2_i);

  tem_pkg::ctl_t c0_q;
  logic [63:0]   rem0_q;
  logic          sat0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
    end else if (en_i) begin
      c0_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem0_q <= 64'(num - (63'd1 << 60));
      sat0_q <= (num <= (63'd1 << 60));
    end
  end

  logic [63:0]   st_rem [RW+1];
  logic [RW-1:0] st_r   [RW+1];
  logic          st_sat [RW+1];
  tem_pkg::ctl_t st_c   [RW+1];

  assign st_rem[0] = rem0_q;
  assign st_r[0]   = '0;
  assign st_sat[0] = sat0_q;
  assign st_c[0]   = c0_q;

  // one root bit per stage, MSB first
  for (genvar j = 0; j < RW; j++) begin : g_bit
    localparam int unsigned I = RW - 1 - j;
    tem_pkg::ctl_t c_q;
    logic [63:0]   rem_q;
    logic [RW-1:0] r_q;
    logic          sat_q;
    logic [63:0]   cand;
    logic          take;

    assign cand = (64'(st_r[j]) << (I + 1)) | (64'd1 << (2 * I));
    assign take = (st_rem[j] >= cand);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_q <= '0;
      end else if (en_i) begin
        c_q <= st_c[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= take ? st_rem[j] - cand : st_rem[j];
        r_q   <= take ? st_r[j] | (RW'(1) << I) : st_r[j];
        sat_q <= st_sat[j];
      end
    end

    assign st_rem[j+1] = rem_q;
    assign st_r[j+1]   = r_q;
    assign st_sat[j+1] = sat_q;
    assign st_c[j+1]   = c_q;
  end

  assign ctl_o  = st_c[RW];
  assign root_o = st_r[RW];
  assign sat_o  = st_sat[RW];

endmodule

/* hdl/tem_div.sv */
module tem_div #(
  parameter int unsigned OUT_FRAC_BITS = tem_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  tem_pkg::ctl_t                    ctl_i,
  input  logic [tem_pkg::DIVISOR_W-1:0]    divisor_i,
  input  logic [tem_pkg::ROOT_W-1:0]       root_i,
  input  logic                             sat_i,
  output tem_pkg::ctl_t                    ctl_o,
  output logic [tem_pkg::FACTOR_W-1:0]     factor_o,
  output logic                             sat_o
);

  localparam int unsigned FW    = tem_pkg::FACTOR_W;
  localparam int unsigned NUM_W = tem_pkg::DIVISOR_W + OUT_FRAC_BITS;
  localparam int unsigned LIM_W = tem_pkg::ROOT_W + FW;
  localparam int unsigned DW    = (NUM_W > LIM_W) ? NUM_W : LIM_W;

  logic [DW-1:0] num;
  logic [DW-1:0] lim;
  assign num = DW'(divisor_i) << OUT_FRAC_BITS;
  assign lim = DW'(root_i) << FW;

  tem_pkg::ctl_t c0_q;
  logic [DW-1:0] rem0_q;
  logic [tem_pkg::ROOT_W-1:0] r0_q;
  logic          sat0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
    end else if (en_i) begin
      c0_q <= ctl_i;
    end
  end

  // quotient past the field (or zero root) saturates
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem0_q <= num;
      r0_q   <= root_i;
      sat0_q <= sat_i | (num >= lim);
    end
  end

  logic [DW-1:0]              st_rem [FW+1];
  logic [tem_pkg::ROOT_W-1:0] st_r   [FW+1];
  logic [FW-1:0]              st_q   [FW+1];
  logic                       st_sat [FW+1];
  tem_pkg::ctl_t              st_c   [FW+1];

  assign st_rem[0] = rem0_q;
  assign st_r[0]   = r0_q;
  assign st_q[0]   = '0;
  assign st_sat[0] = sat0_q;
  assign st_c[0]   = c0_q;

  for (genvar j = 0; j < FW; j++) begin : g_bit
    localparam int unsigned I = FW - 1 - j;
    tem_pkg::ctl_t c_q;
    logic [DW-1:0] rem_q;
    logic [tem_pkg::ROOT_W-1:0] r_q;
    logic [FW-1:0] q_q;
    logic          sat_q;
    logic [DW-1:0] trial;
    logic          take;

    assign trial = DW'(st_r[j]) << I;
    assign take  = (st_rem[j] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_q <= '0;
      end else if (en_i) begin
        c_q <= st_c[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= take ? st_rem[j] - trial : st_rem[j];
        r_q   <= st_r[j];
        q_q   <= take ? st_q[j] | (FW'(1) << I) : st_q[j];
        sat_q <= st_sat[j];
      end
    end

    assign st_rem[j+1] = rem_q;
    assign st_r[j+1]   = r_q;
    assign st_q[j+1]   = q_q;
    assign st_sat[j+1] = sat_q;
    assign st_c[j+1]   = c_q;
  end

  assign ctl_o    = st_c[FW];
  assign factor_o = st_sat[FW] ? tem_pkg::FACTOR_MAX : st_q[FW];
  assign sat_o    = st_sat[FW];

endmodule
